/* hdl/rbi_pkg.sv */
// Shared widths, types and helpers for the 2-D ray versus box intersection core.
`timescale 1ns / 1ps
`default_nettype none
package rbi_pkg;

    localparam int CW   = 24;            // coordinate width
    localparam int TF   = 16;            // fraction bits of the ray parameter
    localparam int EW   = CW + 1;        // box edge width (left + width)
    localparam int DW   = EW + 1;        // plane minus origin
    localparam int NUMW = EW + TF;       // dividend magnitude width
    localparam int DENW = CW;            // divisor magnitude width
    localparam int TW   = 32;            // ray parameter width
    localparam int PW   = TW + CW;       // t * dir product width
    localparam int XW   = PW + 1 - TF;   // rounded, shifted product width
    localparam int CRW  = XW + 1;        // crossing coordinate width
    localparam int SQW  = 2 * CW;        // square width

    localparam int IN_W  = 216;
    localparam int OUT_W = 56;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [EW-1:0] edge_t;
    typedef logic signed [1:0]    norm_t;
    typedef logic signed [TW-1:0] tpar_t;

    localparam tpar_t T_NONE = -(tpar_t'(1) <<< TF);

    // geometry of one request, carried alongside the dividers
    typedef struct packed {
        coord_t          ox;
        coord_t          oy;
        coord_t          dx;
        coord_t          dy;
        edge_t           left;
        edge_t           right;
        edge_t           top;
        edge_t           bottom;
        logic [CW-1:0]   lim;
        norm_t           qx;
        norm_t           qy;
        edge_t           cx;
        edge_t           cy;
        logic            nonex;
        logic            noney;
        logic            negx;
        logic            negy;
        logic            in_box;
    } sb_t;

endpackage
`default_nettype wire

/* hdl/rbi_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module rbi_div_pipe (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic [rbi_pkg::NUMW-1:0] num,
    input  wire logic [rbi_pkg::DENW-1:0] den,
    output logic      [rbi_pkg::NUMW-1:0] quot,
    output logic                          rem_nz
);

    logic [rbi_pkg::DENW-1:0] rem_reg [rbi_pkg::NUMW];
    logic [rbi_pkg::NUMW-1:0] nq_reg  [rbi_pkg::NUMW];
    logic [rbi_pkg::DENW-1:0] den_reg [rbi_pkg::NUMW];

    for (genvar k = 0; k < rbi_pkg::NUMW; k++) begin : g_stage
        logic [rbi_pkg::DENW-1:0] rem_in;
        logic [rbi_pkg::NUMW-1:0] nq_in;
        logic [rbi_pkg::DENW-1:0] den_in;
        logic [rbi_pkg::DENW:0]   trial;
        logic [rbi_pkg::DENW:0]   diff;
        logic                     ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign nq_in  = nq_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        assign trial = {rem_in, nq_in[rbi_pkg::NUMW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[rbi_pkg::DENW-1:0] : trial[rbi_pkg::DENW-1:0];
                nq_reg[k]  <= {nq_in[rbi_pkg::NUMW-2:0], ge};
                den_reg[k] <= den_in;
            end
        end
    end

    assign quot   = nq_reg[rbi_pkg::NUMW-1];
    assign rem_nz = |rem_reg[rbi_pkg::NUMW-1];

endmodule
`default_nettype wire

/* hdl/ray_box_intersect_2d_core.sv */
// Top level: streaming 2-D ray versus axis-aligned box intersection pipeline.
// Pipeline: input register, 41 divider stages with the setup folded into the first, then
// parameter fix-up, multiply, crossing, slab/range, squares, output.
// Throughput: one request per cycle unless the result side stalls; the two 41-stage
// restoring dividers set the depth.
// A stall on the result side freezes the whole pipeline; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_intersect_2d_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // box_left, box_top, box_width, box_height, origin_x, origin_y,
    // dir_x, dir_y, max_length (lowest bit up), zero padded
    input  wire logic [rbi_pkg::IN_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // hit, contact_x, contact_y, normal_x, normal_y (lowest bit up), zero padded
    output logic      [rbi_pkg::OUT_W-1:0]   m_tdata
);

    localparam int CW   = rbi_pkg::CW;
    localparam int EW   = rbi_pkg::EW;
    localparam int NUMW = rbi_pkg::NUMW;

    // saturate an edge-width value to the coordinate range
    function automatic rbi_pkg::coord_t sat_coord(input rbi_pkg::edge_t v);
        rbi_pkg::edge_t hi;
        rbi_pkg::edge_t lo;
        hi = rbi_pkg::edge_t'({1'b0, {(CW-1){1'b1}}});
        lo = -hi - rbi_pkg::edge_t'(1);
        if (v > hi)      sat_coord = hi[CW-1:0];
        else if (v < lo) sat_coord = lo[CW-1:0];
        else             sat_coord = v[CW-1:0];
    endfunction

    // floor-rounded signed quotient from magnitude result, saturated to 32 bits
    function automatic rbi_pkg::tpar_t fix_t(input logic [NUMW-1:0] qm, input logic rnz,
                                             input logic neg, input logic none);
        logic [NUMW:0] mag;
        if (none) begin
            fix_t = rbi_pkg::T_NONE;
        end else begin
            mag = {1'b0, qm} + {{NUMW{1'b0}}, neg & rnz};
            if (!neg) begin
                if (mag > (NUMW+1)'(32'h7fff_ffff)) fix_t = 32'sh7fff_ffff;
                else                                fix_t = mag[rbi_pkg::TW-1:0];
            end else begin
                if (mag > (NUMW+1)'(33'h0_8000_0000)) fix_t = 32'sh8000_0000;
                else                                  fix_t = -mag[rbi_pkg::TW-1:0];
            end
        end
    endfunction

    // hold every stage while a result waits
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- input register
    logic                   v_in_reg;
    logic [rbi_pkg::IN_W-1:0] in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_in_reg <= 1'b0;
        end else if (en) begin
            v_in_reg <= s_tvalid;
        end
        if (en) begin
            in_reg <= s_tdata;
        end
    end

    // ---------------- setup: edges, slab sides, candidate planes, divider operands
    rbi_pkg::coord_t in_left, in_top, in_ox, in_oy, in_dx, in_dy;
    logic [CW-2:0]   in_wid, in_hgt;
    rbi_pkg::sb_t    sb_next;
    logic signed [rbi_pkg::DW-1:0] difx, dify;
    logic [EW-1:0]   magx, magy;
    logic [NUMW-1:0] numx_next, numy_next;
    logic [CW-1:0]   denx_next, deny_next;

    assign in_left = in_reg[23:0];
    assign in_top  = in_reg[47:24];
    assign in_wid  = in_reg[70:48];
    assign in_hgt  = in_reg[93:71];
    assign in_ox   = in_reg[117:94];
    assign in_oy   = in_reg[141:118];
    assign in_dx   = in_reg[165:142];
    assign in_dy   = in_reg[189:166];

    always_comb begin
        sb_next.ox     = in_ox;
        sb_next.oy     = in_oy;
        sb_next.dx     = in_dx;
        sb_next.dy     = in_dy;
        sb_next.lim    = in_reg[213:190];
        sb_next.left   = EW'(in_left);
        sb_next.top    = EW'(in_top);
        sb_next.right  = EW'(in_left) + $signed({2'b00, in_wid});
        sb_next.bottom = EW'(in_top) + $signed({2'b00, in_hgt});
        if (EW'(in_ox) < sb_next.left)       sb_next.qx = -2'sd1;
        else if (EW'(in_ox) > sb_next.right) sb_next.qx = 2'sd1;
        else                                 sb_next.qx = 2'sd0;
        if (EW'(in_oy) < sb_next.top)         sb_next.qy = -2'sd1;
        else if (EW'(in_oy) > sb_next.bottom) sb_next.qy = 2'sd1;
        else                                  sb_next.qy = 2'sd0;
        sb_next.cx     = (sb_next.qx == 2'sd1) ? sb_next.right : sb_next.left;
        sb_next.cy     = (sb_next.qy == 2'sd1) ? sb_next.bottom : sb_next.top;
        sb_next.in_box = (sb_next.qx == 2'sd0) && (sb_next.qy == 2'sd0);
        sb_next.nonex  = (sb_next.qx == 2'sd0) || (in_dx == '0);
        sb_next.noney  = (sb_next.qy == 2'sd0) || (in_dy == '0);
        difx = rbi_pkg::DW'(sb_next.cx) - rbi_pkg::DW'(in_ox);
        dify = rbi_pkg::DW'(sb_next.cy) - rbi_pkg::DW'(in_oy);
        magx = difx[rbi_pkg::DW-1] ? EW'(-difx) : EW'(difx);
        magy = dify[rbi_pkg::DW-1] ? EW'(-dify) : EW'(dify);
        sb_next.negx = difx[rbi_pkg::DW-1] ^ in_dx[CW-1];
        sb_next.negy = dify[rbi_pkg::DW-1] ^ in_dy[CW-1];
        numx_next = {magx, {rbi_pkg::TF{1'b0}}};
        numy_next = {magy, {rbi_pkg::TF{1'b0}}};
        denx_next = in_dx[CW-1] ? CW'(-in_dx) : in_dx;
        deny_next = in_dy[CW-1] ? CW'(-in_dy) : in_dy;
    end

    // setup is combinational; the divider's first stage registers the operands
    logic [NUMW-1:0] qmx, qmy;
    logic            rnzx, rnzy;

    rbi_div_pipe u_div_x (
        .aclk   (aclk),
        .en     (en),
        .num    (numx_next),
        .den    (denx_next),
        .quot   (qmx),
        .rem_nz (rnzx)
    );

    rbi_div_pipe u_div_y (
        .aclk   (aclk),
        .en     (en),
        .num    (numy_next),
        .den    (deny_next),
        .quot   (qmy),
        .rem_nz (rnzy)
    );

    // sideband delay line matching the dividers
    rbi_pkg::sb_t sb_reg [NUMW];
    logic         sv_reg [NUMW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUMW; i++) sv_reg[i] <= 1'b0;
        end else if (en) begin
            sv_reg[0] <= v_in_reg;
            for (int i = 1; i < NUMW; i++) sv_reg[i] <= sv_reg[i-1];
        end
        if (en) begin
            sb_reg[0] <= sb_next;
            for (int i = 1; i < NUMW; i++) sb_reg[i] <= sb_reg[i-1];
        end
    end

    // ---------------- parameter fix-up: floor rounding, saturation, no-candidate
    rbi_pkg::tpar_t tx_reg, ty_reg;
    rbi_pkg::sb_t   sbt_reg;
    logic           vt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vt_reg <= 1'b0;
        end else if (en) begin
            vt_reg <= sv_reg[NUMW-1];
        end
        if (en) begin
            sbt_reg <= sb_reg[NUMW-1];
            tx_reg  <= fix_t(qmx, rnzx, sb_reg[NUMW-1].negx, sb_reg[NUMW-1].nonex);
            ty_reg  <= fix_t(qmy, rnzy, sb_reg[NUMW-1].negy, sb_reg[NUMW-1].noney);
        end
    end

    // ---------------- plane choice and t * dir
    logic                          ysel_c;
    rbi_pkg::tpar_t                t_c;
    logic signed [rbi_pkg::PW-1:0] prod_reg;
    logic                          ysel_reg, neg_reg, vc_reg;
    rbi_pkg::sb_t                  sbc_reg;

    assign ysel_c = tx_reg < ty_reg;
    assign t_c    = ysel_c ? ty_reg : tx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= vt_reg;
        end
        if (en) begin
            sbc_reg  <= sbt_reg;
            ysel_reg <= ysel_c;
            neg_reg  <= t_c[rbi_pkg::TW-1];
            prod_reg <= rbi_pkg::PW'(t_c) * rbi_pkg::PW'(ysel_c ? sbt_reg.dx : sbt_reg.dy);
        end
    end

    // ---------------- crossing coordinate, product rounded half up
    logic signed [rbi_pkg::PW:0]    prnd;
    logic signed [rbi_pkg::CRW-1:0] cross_next, cross_reg;
    logic                           ysel_d_reg, neg_d_reg, vd_reg;
    rbi_pkg::sb_t                   sbd_reg;

    assign prnd       = (rbi_pkg::PW+1)'(prod_reg) + (rbi_pkg::PW+1)'(1 <<< (rbi_pkg::TF-1));
    assign cross_next = rbi_pkg::CRW'(ysel_reg ? sbc_reg.ox : sbc_reg.oy)
                      + rbi_pkg::CRW'($signed(prnd[rbi_pkg::PW:rbi_pkg::TF]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= vc_reg;
        end
        if (en) begin
            sbd_reg    <= sbc_reg;
            ysel_d_reg <= ysel_reg;
            neg_d_reg  <= neg_reg;
            cross_reg  <= cross_next;
        end
    end

    // ---------------- slab test on the other axis, per-axis range check
    logic signed [rbi_pkg::CRW-1:0] px_w, py_w;
    logic                           slab_ok;
    rbi_pkg::edge_t                 pxs, pys;
    logic signed [rbi_pkg::DW-1:0]  ddx, ddy;
    logic [rbi_pkg::DW-1:0]         ex_w, ey_w;
    logic                           near_ok;

    always_comb begin
        if (ysel_d_reg) begin
            px_w    = cross_reg;
            py_w    = rbi_pkg::CRW'(sbd_reg.cy);
            slab_ok = (px_w >= rbi_pkg::CRW'(sbd_reg.left))
                   && (px_w <= rbi_pkg::CRW'(sbd_reg.right));
        end else begin
            px_w    = rbi_pkg::CRW'(sbd_reg.cx);
            py_w    = cross_reg;
            slab_ok = (py_w >= rbi_pkg::CRW'(sbd_reg.top))
                   && (py_w <= rbi_pkg::CRW'(sbd_reg.bottom));
        end
        pxs  = px_w[EW-1:0];
        pys  = py_w[EW-1:0];
        ddx  = rbi_pkg::DW'(pxs) - rbi_pkg::DW'(sbd_reg.ox);
        ddy  = rbi_pkg::DW'(pys) - rbi_pkg::DW'(sbd_reg.oy);
        ex_w = ddx[rbi_pkg::DW-1] ? rbi_pkg::DW'(-ddx) : rbi_pkg::DW'(ddx);
        ey_w = ddy[rbi_pkg::DW-1] ? rbi_pkg::DW'(-ddy) : rbi_pkg::DW'(ddy);
        near_ok = (ex_w <= rbi_pkg::DW'(sbd_reg.lim)) && (ey_w <= rbi_pkg::DW'(sbd_reg.lim));
    end

    typedef struct packed {
        logic            in_box;
        logic            ok;
        rbi_pkg::coord_t ox;
        rbi_pkg::coord_t oy;
        rbi_pkg::edge_t  px;
        rbi_pkg::edge_t  py;
        rbi_pkg::norm_t  nx;
        rbi_pkg::norm_t  ny;
    } res_t;

    res_t          rse_reg;
    logic [CW-1:0] ex_reg, ey_reg, lim_reg;
    logic          ve_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
        end else if (en) begin
            ve_reg <= vd_reg;
        end
        if (en) begin
            rse_reg.in_box <= sbd_reg.in_box;
            rse_reg.ok     <= !neg_d_reg && slab_ok && near_ok;
            rse_reg.ox     <= sbd_reg.ox;
            rse_reg.oy     <= sbd_reg.oy;
            rse_reg.px     <= pxs;
            rse_reg.py     <= pys;
            rse_reg.nx     <= ysel_d_reg ? 2'sd0 : sbd_reg.qx;
            rse_reg.ny     <= ysel_d_reg ? sbd_reg.qy : 2'sd0;
            ex_reg         <= ex_w[CW-1:0];
            ey_reg         <= ey_w[CW-1:0];
            lim_reg        <= sbd_reg.lim;
        end
    end

    // ---------------- squares
    logic [rbi_pkg::SQW-1:0] sqx_reg, sqy_reg, sql_reg;
    res_t                    rsg_reg;
    logic                    vg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vg_reg <= 1'b0;
        end else if (en) begin
            vg_reg <= ve_reg;
        end
        if (en) begin
            rsg_reg <= rse_reg;
            sqx_reg <= rbi_pkg::SQW'(ex_reg) * rbi_pkg::SQW'(ex_reg);
            sqy_reg <= rbi_pkg::SQW'(ey_reg) * rbi_pkg::SQW'(ey_reg);
            sql_reg <= rbi_pkg::SQW'(lim_reg) * rbi_pkg::SQW'(lim_reg);
        end
    end

    // ---------------- distance compare and output register
    logic                       far;
    logic [rbi_pkg::OUT_W-1:0]  out_next;
    logic                       out_v_reg;
    logic [rbi_pkg::OUT_W-1:0]  out_reg;

    assign far = ({1'b0, sqx_reg} + {1'b0, sqy_reg}) > {1'b0, sql_reg};

    always_comb begin
        out_next = '0;
        if (rsg_reg.in_box) begin
            out_next[0]     = 1'b1;
            out_next[24:1]  = rsg_reg.ox;
            out_next[48:25] = rsg_reg.oy;
        end else if (rsg_reg.ok && !far) begin
            out_next[0]     = 1'b1;
            out_next[24:1]  = sat_coord(rsg_reg.px);
            out_next[48:25] = sat_coord(rsg_reg.py);
            out_next[50:49] = rsg_reg.nx;
            out_next[52:51] = rsg_reg.ny;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= vg_reg;
        end
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

endmodule
`default_nettype wire

/* hdl/rbi_checker.sv */
// Port-level checker for the ray/box core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rbi_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [rbi_pkg::OUT_W-1:0] m_tdata
);

    // input side opens exactly when the result register can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow result-side flow");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[rbi_pkg::OUT_W-1:1] == '0)
        else $error("miss with nonzero payload");

    // at most one face normal, and never the code for -2
    a_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[50:49] != 2'b00 && m_tdata[52:51] != 2'b00)
                  && m_tdata[50:49] != 2'b10 && m_tdata[52:51] != 2'b10)
        else $error("bad normal code");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ray_box_intersect_2d_core rbi_checker u_rbi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
